### rtl/rkxb_pkg.sv
// Shared types, constants and the Base64 symbol function for the XOR/Base64 encoder.
package rkxb_pkg;

  localparam int MaxKeyBytesDefault = 8;
  localparam int QueueDepth         = 4;
  localparam int KeyBytesWidth      = 64;
  localparam int KeyLenWidth        = 4;
  localparam int CfgAddrWidth       = 4;
  localparam int CfgDataWidth       = 64;

  localparam logic [KeyBytesWidth-1:0] KeyBytesReset = 64'h0000_0036_3235_3733;
  localparam logic [KeyLenWidth-1:0]   KeyLenReset   = 4'd5;

  localparam logic [7:0] PadChar = 8'h3d;  // '='

  // one queue entry: the characters caused by one message byte
  typedef struct packed {
    logic [3:0][7:0] chars;   // chars[0] goes out first
    logic [1:0]      cnt_m1;  // number of valid chars minus one
    logic            last;    // final char of the entry closes the message
  } rkxb_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rkxb_qstat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] sym);
    logic [7:0] s;
    s = {2'b00, sym};
    if (sym < 6'd26)      return s + 8'd65;   // 'A'
    else if (sym < 6'd52) return s + 8'd71;   // 'a' - 26
    else if (sym < 6'd62) return s - 8'd4;    // '0' - 52
    else if (sym == 6'd62) return 8'h2b;      // '+'
    else                   return 8'h2f;      // '/'
  endfunction

endpackage

### rtl/repeating_key_xor_base64_encoder.sv
// Top level: repeating-key XOR then Base64 encoder with APB key registers.
// An accepted byte passes the queue slot, then the output register, before reaching out_.
// Throughput: one byte per cycle enters while the 4-entry queue has room; the output
// register sends one character per cycle while out_ready is high, so the character
// stream (4/3 per byte, up to four on a last byte) sets the sustained byte rate.
// Reset (synchronous, rst_n low): key "37526", key length 5, key position and group cleared.
module repeating_key_xor_base64_encoder #(
  parameter int MAX_KEY_BYTES = rkxb_pkg::MaxKeyBytesDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // last_byte
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] text_char
  output logic                               out_tlast,  // last_char
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rkxb_pkg::CfgAddrWidth-1:0]  cfg_paddr,
  input  logic [rkxb_pkg::CfgDataWidth-1:0]  cfg_pwdata,
  output logic [rkxb_pkg::CfgDataWidth-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import rkxb_pkg::*;

  // register map: 0x0 key_bytes (first key byte in [7:0]), 0x8 key_length
  logic [KeyBytesWidth-1:0] key_bytes_r;
  logic [KeyLenWidth-1:0]   key_len_r;
  logic                     cfg_wr;

  rkxb_entry_t push_entry, head_entry;
  rkxb_qstat_t qstat;
  logic        push, pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // decode on address bit 3 only; lower bits are don't-care
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r <= KeyBytesReset;
      key_len_r   <= KeyLenReset;
    end else if (cfg_wr) begin
      if (cfg_paddr[3]) key_len_r   <= cfg_pwdata[KeyLenWidth-1:0];
      else              key_bytes_r <= cfg_pwdata[KeyBytesWidth-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[3] ? {{(CfgDataWidth-KeyLenWidth){1'b0}}, key_len_r}
                                   : key_bytes_r;

  // front: XOR and Base64 grouping, one queue entry per accepted byte
  rkxb_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .key_bytes (key_bytes_r),
    .key_len   (key_len_r),
    .qstat     (qstat),
    .in_ready  (in_tready),
    .push      (push),
    .push_entry(push_entry)
  );

  // decoupling queue: lets the input side keep going while characters drain
  rkxb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head_entry(head_entry),
    .qstat     (qstat)
  );

  // back: one character per transaction on the result stream
  rkxb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_entry(head_entry),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule

### rtl/rkxb_front.sv
// Front end: key XOR, Base64 grouping and padding, one queue entry per byte.
module rkxb_front #(
  parameter int MAX_KEY_BYTES = rkxb_pkg::MaxKeyBytesDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [7:0]                          in_byte,
  input  logic                                in_last,
  input  logic [rkxb_pkg::KeyBytesWidth-1:0]  key_bytes,
  input  logic [rkxb_pkg::KeyLenWidth-1:0]    key_len,
  input  rkxb_pkg::rkxb_qstat_t               qstat,
  output logic                                in_ready,
  output logic                                push,
  output rkxb_pkg::rkxb_entry_t               push_entry
);
  import rkxb_pkg::*;

  localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KeyLenWidth-1:0] MaxLen = KeyLenWidth'(MAX_KEY_BYTES);

  logic [KPW-1:0] key_pos_r, key_pos_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic [3:0]     left_r, left_nxt;

  logic [KeyLenWidth-1:0] eff_len;
  logic [KeyLenWidth-1:0] pos_inc;
  logic [7:0]             kb, x;
  rkxb_entry_t            ent;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    if (key_len == '0)         eff_len = KeyLenWidth'(1);
    else if (key_len > MaxLen) eff_len = MaxLen;
    else                       eff_len = key_len;
  end

  assign kb      = key_bytes[8*key_pos_r +: 8];
  assign x       = in_byte ^ kb;
  assign pos_inc = KeyLenWidth'(key_pos_r) + KeyLenWidth'(1);

  always_comb begin
    ent         = '0;
    ent.last    = in_last;
    left_nxt    = left_r;
    phase_nxt   = phase_r;
    key_pos_nxt = (pos_inc >= eff_len) ? '0 : key_pos_r + KPW'(1);
    case (phase_r)
      2'd0: begin
        ent.chars[0] = b64_char(x[7:2]);
        ent.cnt_m1   = 2'd0;
        left_nxt     = {2'b00, x[1:0]};
        phase_nxt    = 2'd1;
      end
      2'd1: begin
        ent.chars[0] = b64_char({left_r[1:0], x[7:4]});
        ent.cnt_m1   = 2'd0;
        left_nxt     = x[3:0];
        phase_nxt    = 2'd2;
      end
      default: begin
        ent.chars[0] = b64_char({left_r[3:0], x[7:6]});
        ent.chars[1] = b64_char(x[5:0]);
        ent.cnt_m1   = 2'd1;
        left_nxt     = '0;
        phase_nxt    = 2'd0;
      end
    endcase
    if (in_last) begin
      // flush leftover bits and pad to a four-character boundary
      if (phase_nxt == 2'd1) begin
        ent.chars[1] = b64_char({left_nxt[1:0], 4'b0000});
        ent.chars[2] = PadChar;
        ent.chars[3] = PadChar;
        ent.cnt_m1   = 2'd3;
      end else if (phase_nxt == 2'd2) begin
        ent.chars[1] = b64_char({left_nxt[3:0], 2'b00});
        ent.chars[2] = PadChar;
        ent.cnt_m1   = 2'd2;
      end
      key_pos_nxt = '0;
      phase_nxt   = 2'd0;
      left_nxt    = '0;
    end
  end

  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
      phase_r   <= 2'd0;
      left_r    <= '0;
    end else if (push) begin
      key_pos_r <= key_pos_nxt;
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

### rtl/rkxb_queue.sv
// Short entry queue between the front end and the character serializer.
module rkxb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rkxb_pkg::rkxb_entry_t push_entry,
  input  logic                  pop,
  output rkxb_pkg::rkxb_entry_t head_entry,
  output rkxb_pkg::rkxb_qstat_t qstat
);
  import rkxb_pkg::*;

  localparam int PW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  rkxb_entry_t   slots_r [QueueDepth];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  assign qstat.full  = (count_r == CW'(QueueDepth));
  assign qstat.empty = (count_r == '0);
  assign head_entry  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QueueDepth)) else $error("queue count overflow");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("queue pointers diverged");

endmodule

### rtl/rkxb_back.sv
// Back end: sends the characters of each queue entry one per cycle while out_ready is high.
module rkxb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rkxb_pkg::rkxb_entry_t head_entry,
  input  rkxb_pkg::rkxb_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  output logic [7:0]            out_char,
  output logic                  out_last,
  input  logic                  out_ready
);
  import rkxb_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       load;
  logic       at_end;

  assign load   = !qstat.empty && (!out_valid_r || out_ready);
  assign at_end = (idx_r == head_entry.cnt_m1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= at_end ? 2'd0 : idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= head_entry.chars[idx_r];
      out_last_r <= head_entry.last && at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule
